/* design/stls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stls_pkg
// Shared types and constants of the stair light step sequencer.
// ----------------------------------------------------------------------------
package stls_pkg;

	localparam int COUNT_W    = 22;
	localparam int DELAY_W    = 21;
	localparam int STEP_CNT_W = 6;
	localparam int GAP_W      = 14;
	localparam int STAY_W     = 21;
	localparam int MASK_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 21;

	typedef logic signed [COUNT_W-1:0] count_t;
	typedef logic [DELAY_W-1:0]        delay_t;
	typedef logic [STEP_CNT_W-1:0]     step_cnt_t;
	typedef logic [GAP_W-1:0]          gap_t;
	typedef logic [STAY_W-1:0]         stay_t;
	typedef logic [MASK_W-1:0]         mask_t;

	localparam count_t IDLE      = '1;
	localparam delay_t COUNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STAY_ON    = 2'd2;

	// pass token walking down the row of step cells
	typedef struct packed {
		logic   valid;
		logic   sched;
		logic   up;
		logic   tick;
		delay_t delay;
		mask_t  on_mask;
		mask_t  off_mask;
		logic   refresh;
	} token_t;

endpackage

/* design/stls_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stls_if
// Valid/ready channels for sensor passes and step change results.
// ----------------------------------------------------------------------------
interface stls_sensor_if;
	logic valid;
	logic ready;
	logic top_present;
	logic bottom_present;
	logic count_tick;

	modport source (output valid, top_present, bottom_present, count_tick, input ready);
	modport sink   (input valid, top_present, bottom_present, count_tick, output ready);
endinterface

interface stls_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] on_mask;
	logic [31:0] off_mask;
	logic        refresh;

	modport source (output valid, on_mask, off_mask, refresh, input ready);
	modport sink   (input valid, on_mask, off_mask, refresh, output ready);
endinterface

/* design/stair_light_step_sequencer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stair_light_step_sequencer_top
// Stair light step sequencer: a row of step cells through which each sensor
// pass travels as a token, one step per cycle.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  sensor   | in  | top_present, bottom_present, count_tick
//  result   | out | on_mask[31:0], off_mask[31:0], refresh
//  cfg      | in  | cfg_we, cfg_index[1:0], cfg_data[20:0]
//
//  a pass runs through the launch register, the register of each step cell
//  and the result register
//  one pass in flight; sensor ready stays low until its result is taken
//  reset clears all step counts to idle and all registers to zero
// ----------------------------------------------------------------------------
module stair_light_step_sequencer_top
	import stls_pkg::*;
#(
	parameter int MAX_STEPS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	stls_sensor_if.sink           sensor,
	stls_result_if.source         result
);

	step_cnt_t step_count_q;
	gap_t      gap_q;
	stay_t     stay_q;
	step_cnt_t n;
	step_cnt_t n_m1;
	logic [GAP_W+STEP_CNT_W-1:0] prod;
	logic      busy_q;
	logic      accept;
	token_t    launch_s1;
	token_t    tok [MAX_STEPS+1];
	logic      res_valid_q;
	mask_t     res_on_q, res_off_q;
	logic      res_refresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q <= '0;
			gap_q        <= '0;
			stay_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STEP_COUNT: step_count_q <= cfg_data[STEP_CNT_W-1:0];
				CFG_STEP_GAP:   gap_q        <= cfg_data[GAP_W-1:0];
				CFG_STAY_ON:    stay_q       <= cfg_data[STAY_W-1:0];
				default:        ;
			endcase
		end
	end

	assign n      = ({1'b0, step_count_q} > (STEP_CNT_W + 1)'(MAX_STEPS)) ?
	                STEP_CNT_W'(MAX_STEPS) : step_count_q;
	assign n_m1   = (n != '0) ? (n - step_cnt_t'(1)) : '0;
	assign prod   = gap_q * n_m1;
	assign accept = sensor.valid && sensor.ready;
	assign sensor.ready = !busy_q;

	// schedule delay for step 0: zero going up, gap times (n - 1) going down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			launch_s1   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			launch_s1.valid <= accept;
			if (accept) begin
				launch_s1.sched <= sensor.top_present ^ sensor.bottom_present;
				launch_s1.up    <= sensor.bottom_present;
				launch_s1.tick  <= sensor.count_tick;
				launch_s1.delay <= sensor.bottom_present ? '0 : DELAY_W'(prod);
			end
			launch_s1.on_mask  <= '0;
			launch_s1.off_mask <= '0;
			launch_s1.refresh  <= 1'b0;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				busy_q <= 1'b0;
			end
			if (tok[MAX_STEPS].valid) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign tok[0] = launch_s1;

	for (genvar k = 0; k < MAX_STEPS; k++) begin : g_cell
		stls_cell #(
			.INDEX (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.n       (n),
			.gap     (gap_q),
			.stay    (stay_q),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_on_q      <= '0;
			res_off_q     <= '0;
			res_refresh_q <= 1'b0;
		end else if (tok[MAX_STEPS].valid) begin
			res_on_q      <= tok[MAX_STEPS].on_mask;
			res_off_q     <= tok[MAX_STEPS].off_mask;
			res_refresh_q <= tok[MAX_STEPS].refresh;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.on_mask  = res_on_q;
	assign result.off_mask = res_off_q;
	assign result.refresh  = res_refresh_q;

endmodule

/* design/stls_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stls_cell
// One stair step: holds its on and off countdowns, updates them as the pass
// token goes by and hands the token on to the next step.
// ----------------------------------------------------------------------------
module stls_cell
	import stls_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  step_cnt_t n,
	input  gap_t      gap,
	input  stay_t     stay,
	input  token_t    tok_in,
	output token_t    tok_out
);

	localparam logic [STEP_CNT_W:0] IDX      = (STEP_CNT_W + 1)'(INDEX);
	localparam mask_t               BIT_MASK = (INDEX < MASK_W) ? (mask_t'(1) << INDEX) : '0;

	count_t               on_q, off_q;
	count_t               on_d, off_d;
	logic                 active;
	logic                 on_hit, off_hit;
	logic [DELAY_W:0]     sum_up;
	delay_t               delay_nxt;
	token_t               tok_d;
	token_t               tok_s1;

	assign active = {1'b0, n} > IDX;
	assign sum_up = {1'b0, tok_in.delay} + (DELAY_W + 1)'(gap);

	always_comb begin
		if (tok_in.up) begin
			delay_nxt = (sum_up > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum_up[DELAY_W-1:0];
		end else begin
			delay_nxt = (tok_in.delay >= DELAY_W'(gap)) ? (tok_in.delay - DELAY_W'(gap)) : '0;
		end
	end

	always_comb begin
		on_d    = on_q;
		off_d   = off_q;
		on_hit  = 1'b0;
		off_hit = 1'b0;
		if (tok_in.valid && active) begin
			if (tok_in.sched && on_d == IDLE) begin
				on_d  = count_t'({1'b0, tok_in.delay});
				off_d = IDLE;
			end
			if (on_d == '0) begin
				on_hit = 1'b1;
				off_d  = count_t'({1'b0, stay});
			end
			if (off_d == '0) begin
				off_hit = 1'b1;
				off_d   = IDLE;
			end
			if (tok_in.tick) begin
				if (!on_d[COUNT_W-1]) begin
					on_d = on_d - count_t'(1);
				end
				if (!off_d[COUNT_W-1]) begin
					off_d = off_d - count_t'(1);
				end
			end
		end
	end

	always_comb begin
		tok_d          = tok_in;
		tok_d.delay    = delay_nxt;
		tok_d.on_mask  = tok_in.on_mask | (on_hit ? BIT_MASK : '0);
		tok_d.off_mask = tok_in.off_mask | (off_hit ? BIT_MASK : '0);
		tok_d.refresh  = tok_in.refresh | on_hit | off_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q  <= IDLE;
			off_q <= IDLE;
		end else begin
			on_q  <= on_d;
			off_q <= off_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_d;
		end
	end

	assign tok_out = tok_s1;

endmodule

/* design/stls_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stls_checker
// Port level checks of the stair light step sequencer, bound to the top.
// ----------------------------------------------------------------------------
module stls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_valid,
	input logic        s_ready,
	input logic        r_valid,
	input logic        r_ready,
	input logic [31:0] r_on_mask,
	input logic [31:0] r_off_mask,
	input logic        r_refresh
);

	// no new pass while a result is pending
	a_no_accept_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> !s_ready)
		else $error("sensor ready while result pending");

	// one pass in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready) |=> !s_ready)
		else $error("ready right after accepted transaction");

	// any mask bit implies refresh
	a_refresh_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && ((r_on_mask | r_off_mask) != 32'd0)) |-> r_refresh)
		else $error("mask bits without refresh");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && !r_ready) |=> (r_valid && $stable(r_on_mask) && $stable(r_off_mask)))
		else $error("stalled result changed");

endmodule

bind stair_light_step_sequencer_top stls_checker u_stls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.s_valid    (sensor.valid),
	.s_ready    (sensor.ready),
	.r_valid    (result.valid),
	.r_ready    (result.ready),
	.r_on_mask  (result.on_mask),
	.r_off_mask (result.off_mask),
	.r_refresh  (result.refresh)
);

/* bench/stair_light_step_sequencer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stair_light_step_sequencer_top_tb
// Drives sensor passes into the stair light sequencer and checks every step
// change result against an in-bench model of the step countdowns, or against
// a typed row's own masks. A table of directed passes opens and closes the run.
// Register settings change between random phases; both channels idle at random.
// ----------------------------------------------------------------------------
module stair_light_step_sequencer_top_tb;
	import stls_pkg::*;

	localparam int MAX_STEPS        = 32;
	localparam int NUM_PHASES       = 12;
	localparam int PASSES_PER_PHASE = 110;
	localparam int OPENING_ROWS     = 21;
	localparam int NUM_ROWS         = 28;

	typedef struct packed {
		mask_t on_mask;
		mask_t off_mask;
		logic  refresh;
	} step_change_t;

	typedef struct packed {
		logic      write_cfg;
		step_cnt_t cnt;
		gap_t      gap;
		stay_t     stay;
		logic      top;
		logic      bottom;
		logic      tick;
		logic      typed;
		mask_t     on_mask;
		mask_t     off_mask;
		logic      refresh;
	} pass_row_t;

	pass_row_t pass_rows [NUM_ROWS] = '{
		'{1'b1, 6'd0,  14'd0,     21'd0,       1'b0, 1'b1, 1'b1, 1'b1, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b1, 1'b0, 1'b0, 1'b1, 32'h0, 32'h0, 1'b0},
		'{1'b1, 6'd4,  14'd0,     21'd0,       1'b0, 1'b1, 1'b0, 1'b1, 32'hF, 32'hF, 1'b1},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b1, 1'b1, 32'hF, 32'hF, 1'b1},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b1, 1'b1, 32'h0, 32'h0, 1'b0},
		'{1'b1, 6'd32, 14'd1,     21'd2,       1'b1, 1'b0, 1'b0, 1'b1,
			32'h8000_0000, 32'h0, 1'b1},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b1, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b1, 6'd63, 14'd0,     21'd3,       1'b0, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b1, 6'd1,  14'd16383, 21'd2097151, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b1, 6'd33, 14'd0,     21'd1800000, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		// closing rows: large gaps leave steps scheduled far ahead
		'{1'b1, 6'd63, 14'd16383, 21'd2097151, 1'b0, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b1, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b1, 1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b1, 6'd32, 14'd10000, 21'd1800000, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0},
		'{1'b0, 6'd0,  14'd0,     21'd0,       1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 32'h0, 1'b0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	stls_sensor_if sensor_ch ();
	stls_result_if result_ch ();

	stair_light_step_sequencer_top #(
		.MAX_STEPS (MAX_STEPS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sensor    (sensor_ch.sink),
		.result    (result_ch.source)
	);

	step_cnt_t    steps_r;
	gap_t         gap_r;
	stay_t        stay_r;
	count_t       on_cnt  [MAX_STEPS];
	count_t       off_cnt [MAX_STEPS];
	step_change_t expected_changes [$];
	int           mismatch_count;
	bit           no_idle;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// one polling pass over the stair countdowns
	task automatic predict_pass(input logic top, input logic bottom, input logic tick,
			output step_change_t chg);
		int n;
		longint unsigned dly;
		chg = '0;
		n = (steps_r > MAX_STEPS) ? MAX_STEPS : int'(steps_r);
		for (int i = 0; i < n; i++) begin
			if (top != bottom && on_cnt[i] == IDLE) begin
				dly = longint'(gap_r) * longint'(bottom ? i : n - 1 - i);
				if (dly > COUNT_MAX)
					dly = COUNT_MAX;
				on_cnt[i]  = count_t'(dly);
				off_cnt[i] = IDLE;
			end
			if (on_cnt[i] == 0) begin
				if (i < MASK_W)
					chg.on_mask[i] = 1'b1;
				off_cnt[i]  = $signed({1'b0, stay_r});
				chg.refresh = 1'b1;
			end
			if (off_cnt[i] == 0) begin
				if (i < MASK_W)
					chg.off_mask[i] = 1'b1;
				off_cnt[i]  = IDLE;
				chg.refresh = 1'b1;
			end
			if (tick) begin
				if (on_cnt[i] >= 0)
					on_cnt[i] = on_cnt[i] - count_t'(1);
				if (off_cnt[i] >= 0)
					off_cnt[i] = off_cnt[i] - count_t'(1);
			end
		end
	endtask

	task automatic write_regs(input int cnt, input int gap, input int stay, input bit junk);
		logic [CFG_DATA_W-1:0] data;
		data = junk ? CFG_DATA_W'($urandom) : '0;
		data[STEP_CNT_W-1:0] = STEP_CNT_W'(cnt);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_STEP_COUNT;
		cfg_data  <= data;
		steps_r = data[STEP_CNT_W-1:0];
		@(posedge clk);
		data = junk ? CFG_DATA_W'($urandom) : '0;
		data[GAP_W-1:0] = GAP_W'(gap);
		cfg_index <= CFG_STEP_GAP;
		cfg_data  <= data;
		gap_r = data[GAP_W-1:0];
		@(posedge clk);
		data = CFG_DATA_W'(stay);
		cfg_index <= CFG_STAY_ON;
		cfg_data  <= data;
		stay_r = data[STAY_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_results();
		sensor_ch.valid <= 1'b0;
		while (expected_changes.size() != 0)
			@(posedge clk);
	endtask

	// one sensor transaction; valid stays high so a back-to-back pass needs no gap
	task automatic send_pass(input logic top, input logic bottom, input logic tick,
			input bit typed, input step_change_t typed_chg);
		int gap;
		step_change_t chg;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			sensor_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sensor_ch.valid          <= 1'b1;
		sensor_ch.top_present    <= top;
		sensor_ch.bottom_present <= bottom;
		sensor_ch.count_tick     <= tick;
		do @(posedge clk); while (!sensor_ch.ready);
		predict_pass(top, bottom, tick, chg);
		if (typed)
			chg = typed_chg;
		expected_changes = {expected_changes, chg};
	endtask

	task automatic walk_rows(input int first, input int last);
		for (int r = first; r <= last; r++) begin
			if (pass_rows[r].write_cfg) begin
				drain_results();
				write_regs(pass_rows[r].cnt, pass_rows[r].gap, pass_rows[r].stay, 1'b0);
			end
			send_pass(pass_rows[r].top, pass_rows[r].bottom, pass_rows[r].tick,
				pass_rows[r].typed, step_change_t'{pass_rows[r].on_mask,
				pass_rows[r].off_mask, pass_rows[r].refresh});
		end
	endtask

	initial begin
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	always @(posedge clk) begin
		step_change_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_changes.size() == 0) begin
				report_mismatch("result transaction with nothing expected");
			end else begin
				want = expected_changes.pop_front();
				if (result_ch.on_mask !== want.on_mask)
					report_mismatch($sformatf("on_mask %h, expected %h",
						result_ch.on_mask, want.on_mask));
				if (result_ch.off_mask !== want.off_mask)
					report_mismatch($sformatf("off_mask %h, expected %h",
						result_ch.off_mask, want.off_mask));
				if (result_ch.refresh !== want.refresh)
					report_mismatch($sformatf("refresh %b, expected %b",
						result_ch.refresh, want.refresh));
			end
		end
	end

	initial begin
		int   sel;
		int   cnt_v;
		int   gap_v;
		int   stay_v;
		logic top_v;
		logic bottom_v;
		logic tick_v;
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_index                = '0;
		cfg_data                 = '0;
		sensor_ch.valid          = 1'b0;
		sensor_ch.top_present    = 1'b0;
		sensor_ch.bottom_present = 1'b0;
		sensor_ch.count_tick     = 1'b0;
		steps_r                  = '0;
		gap_r                    = '0;
		stay_r                   = '0;
		mismatch_count           = 0;
		no_idle                  = 1'b0;
		for (int i = 0; i < MAX_STEPS; i++) begin
			on_cnt[i]  = IDLE;
			off_cnt[i] = IDLE;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		walk_rows(0, OPENING_ROWS - 1);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_results();
			no_idle = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 9);
			if (sel == 0)
				cnt_v = 0;
			else if (sel == 1)
				cnt_v = $urandom_range(33, 63);
			else if (sel == 2)
				cnt_v = MAX_STEPS;
			else
				cnt_v = $urandom_range(1, 31);
			gap_v  = $urandom_range(0, 3);
			stay_v = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
			write_regs(cnt_v, gap_v, stay_v, ($urandom_range(0, 1) == 1));
			for (int k = 0; k < PASSES_PER_PHASE; k++) begin
				sel      = $urandom_range(0, 9);
				bottom_v = (sel <= 2) || (sel == 6);
				top_v    = (sel >= 3 && sel <= 6);
				tick_v   = ($urandom_range(0, 4) < 3);
				send_pass(top_v, bottom_v, tick_v, 1'b0, '0);
			end
		end

		no_idle = 1'b0;
		walk_rows(OPENING_ROWS, NUM_ROWS - 1);

		drain_results();
		repeat (2 * (MAX_STEPS + 3)) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* stair_light_step_sequencer_top.f */
design/stls_pkg.sv
design/stls_if.sv
design/stls_cell.sv
design/stair_light_step_sequencer_top.sv
design/stls_checker.sv
bench/stair_light_step_sequencer_top_tb.sv
